@@ hw/rtl/skl_pkg.sv @@
// Shared types and constants of the sorted key list table.
`default_nettype none

package skl_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_W    = 8;
  localparam int PAY_W    = 64;
  localparam int AW       = $clog2(CAPACITY);
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int OPC_W    = 3;
  localparam int CNT_OUT_W = 5;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [OPC_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_SORTED     = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_CLEAR      = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

endpackage

`default_nettype wire

@@ hw/rtl/skl_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module skl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/sorted_key_list_table.sv @@
// A command passes S_SCAN, where it reads entries, then S_FINISH and S_RESULT: push back reads
// no entry, pop back reads one and the others read up to the entry count. Clear, the unused
// opcode, a full list and an empty list go straight to S_RESULT. A new item is taken only in
// S_IDLE, after S_RESULT has handed the previous result to the output register.
// A new item is taken while the previous result still waits at the output.
// Reset empties the list at once; the entry RAM itself is not cleared.
`default_nettype none

module sorted_key_list_table
  import skl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic [OPC_W-1:0]     opcode_i,
  input  wire logic [KEY_W-1:0]     key_in_i,
  input  wire logic [PAY_W-1:0]     payload_in_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [1:0]           status_o,
  output      logic [KEY_W-1:0]     key_out_o,
  output      logic [PAY_W-1:0]     payload_out_o,
  output      logic [CNT_OUT_W-1:0] entry_count_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   rd_ptr_q, rd_ptr_d;
  logic            d_vld_q, d_vld_d;
  logic [AW-1:0]   d_idx_q, d_idx_d;
  logic            found_q, found_d;
  logic            ins_q, ins_d;
  logic            out_valid_q, out_valid_d;
  status_e         st_q, st_d;

  logic [OPC_W-1:0] op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  entry_t           carry_q, carry_d;
  entry_t           res_q, res_d;
  logic [1:0]       out_st_q, out_st_d;
  entry_t           out_ent_q, out_ent_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  entry_t          ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t          rd_ent;
  logic            accept;
  logic            hit;

  assign rd_ent = entry_t'(ram_rdata);
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  skl_ram #(
    .Width (ENTRY_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    d_vld_d     = 1'b0;
    d_idx_d     = d_idx_q;
    found_d     = found_q;
    ins_d       = ins_q;
    st_d        = st_q;
    op_d        = op_q;
    key_d       = key_q;
    carry_d     = carry_q;
    res_d       = res_q;
    out_st_d    = out_st_q;
    out_ent_d   = out_ent_q;
    out_cnt_d   = out_cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = carry_q;
    ram_re      = 1'b0;
    ram_raddr   = rd_ptr_q[AW-1:0];
    hit         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = opcode_i;
          key_d   = key_in_i;
          carry_d = '{key: key_in_i, payload: payload_in_i};
          res_d   = '0;
          st_d    = ST_OK;
          found_d = (opcode_i == OP_PUSH_FRONT);
          ins_d   = (opcode_i == OP_PUSH_FRONT) || (opcode_i == OP_PUSH_BACK) ||
                    (opcode_i == OP_SORTED);
          state_d = S_RESULT;
          unique case (opcode_i)
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED: begin
              if (cnt_q == CW'(CAPACITY)) begin
                st_d = ST_FULL;
              end else begin
                rd_ptr_d = (opcode_i == OP_PUSH_BACK) ? cnt_q : '0;
                state_d  = S_SCAN;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_REMOVE: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                rd_ptr_d = (opcode_i == OP_POP_BACK) ? (cnt_q - CW'(1)) : '0;
                state_d  = S_SCAN;
              end
            end
            OP_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // Reads run one entry ahead of the entry being handled, so the write
        // below never lands on the address being read.
        if (rd_ptr_q < cnt_q) begin
          ram_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + CW'(1);
          d_vld_d  = 1'b1;
          d_idx_d  = rd_ptr_q[AW-1:0];
        end else begin
          state_d = S_FINISH;
        end

        if (d_vld_q) begin
          if (ins_q) begin
            // Once the place is found, every later entry moves up by one via
            // the carry register, the new entry going first.
            if (d_idx_q == '0) begin
              hit = found_q || ((op_q == OP_SORTED) && (key_q < rd_ent.key));
            end else begin
              hit = found_q || ((op_q == OP_SORTED) && (rd_ent.key >= key_q));
            end
            if (hit) begin
              ram_we    = 1'b1;
              ram_waddr = d_idx_q;
              ram_wdata = carry_q;
              carry_d   = rd_ent;
              found_d   = 1'b1;
            end
          end else if (found_q) begin
            ram_we    = 1'b1;
            ram_waddr = d_idx_q - AW'(1);
            ram_wdata = rd_ent;
          end else if ((op_q != OP_REMOVE) || (rd_ent.key == key_q)) begin
            res_d   = rd_ent;
            found_d = 1'b1;
          end
        end
      end

      S_FINISH: begin
        state_d = S_RESULT;
        if (ins_q) begin
          ram_we    = 1'b1;
          ram_waddr = cnt_q[AW-1:0];
          ram_wdata = carry_q;
          cnt_d     = cnt_q + CW'(1);
        end else if (found_q) begin
          cnt_d = cnt_q - CW'(1);
        end else begin
          st_d = ST_NOT_FOUND;
        end
      end

      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          out_ent_d   = res_q;
          out_cnt_d   = CNT_OUT_W'(cnt_q);
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rd_ptr_q    <= '0;
      d_vld_q     <= 1'b0;
      found_q     <= 1'b0;
      ins_q       <= 1'b0;
      st_q        <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_ptr_q    <= rd_ptr_d;
      d_vld_q     <= d_vld_d;
      found_q     <= found_d;
      ins_q       <= ins_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_idx_q   <= d_idx_d;
    op_q      <= op_d;
    key_q     <= key_d;
    carry_q   <= carry_d;
    res_q     <= res_d;
    out_st_q  <= out_st_d;
    out_ent_q <= out_ent_d;
    out_cnt_q <= out_cnt_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_st_q;
  assign key_out_o     = out_ent_q.key;
  assign payload_out_o = out_ent_q.payload;
  assign entry_count_o = out_cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("RAM read and write hit the same entry");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_vld_q |-> (CW'(d_idx_q) < cnt_q))
    else $error("scan handled an entry beyond the list");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_RESULT) && (st_q == ST_FULL)) |-> (cnt_q == CW'(CAPACITY)))
    else $error("full status on a list that is not full");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (opcode_i == OP_CLEAR)) |=> (cnt_q == '0))
    else $error("clear left entries behind");

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench of the sorted key list table, with a table-driven and a random part.
module tb;
  import skl_pkg::*;

  localparam logic [OPC_W-1:0] OPC_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int RX_HOLD_CYCLES = 120;
  localparam int MAX_REPORTS    = 10;
  localparam int N_DIRECTED     = 20;

  typedef struct packed {
    status_e                status;
    logic [KEY_W-1:0]       key;
    logic [PAY_W-1:0]       payload;
    logic [CNT_OUT_W-1:0]   count;
  } outcome_t;

  typedef struct {
    logic [OPC_W-1:0] opcode;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    int               reps;
    bit               rand_data;
    bit               typed;
    outcome_t         outcome;
  } step_t;

  localparam outcome_t NO_OUTCOME = '{ST_OK, '0, '0, '0};
  localparam logic [PAY_W-1:0] PAY_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [OPC_W-1:0]     opcode_i      = '0;
  logic [KEY_W-1:0]     key_in_i      = '0;
  logic [PAY_W-1:0]     payload_in_i  = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b0;
  logic [1:0]           status_o;
  logic [KEY_W-1:0]     key_out_o;
  logic [PAY_W-1:0]     payload_out_o;
  logic [CNT_OUT_W-1:0] entry_count_o;

  // Shadow copy of the list, front at index 0.
  logic [KEY_W-1:0] list_keys [CAPACITY];
  logic [PAY_W-1:0] list_pays [CAPACITY];
  int               list_fill = 0;

  outcome_t expected_results[$];
  int       mismatches = 0;
  int       cycle_cnt  = 0;
  bit       rx_hold_req = 1'b0;
  bit       rx_holding  = 1'b0;

  step_t directed_steps [N_DIRECTED] = '{
    '{OP_POP_FRONT,  8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_EMPTY, '0, '0, 5'd0}},
    '{OP_POP_BACK,   8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_EMPTY, '0, '0, 5'd0}},
    '{OP_REMOVE,     8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_EMPTY, '0, '0, 5'd0}},
    '{OPC_UNUSED,    8'hFF, PAY_ONES, 1, 1'b0, 1'b1, '{ST_OK, '0, '0, 5'd0}},
    '{OP_PUSH_FRONT, 8'hFF, PAY_ONES, 1, 1'b0, 1'b1, '{ST_OK, '0, '0, 5'd1}},
    '{OP_POP_FRONT,  8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_OK, 8'hFF, PAY_ONES, 5'd0}},
    '{OP_SORTED,     8'd80, 64'd1,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_SORTED,     8'd80, 64'd2,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_SORTED,     8'd10, 64'd3,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_SORTED,     8'd80, 64'd4,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_SORTED,     8'hFF, 64'd5,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_PUSH_BACK,  8'h00, 64'h0,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_REMOVE,     8'd80, 64'h0,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_REMOVE,     8'd200, 64'h0,   1, 1'b0, 1'b1, '{ST_NOT_FOUND, '0, '0, 5'd5}},
    '{OP_POP_BACK,   8'h00, 64'h0,    1, 1'b0, 1'b0, NO_OUTCOME},
    '{OP_CLEAR,      8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_OK, '0, '0, 5'd0}},
    '{OP_PUSH_BACK,  8'h00, 64'h0,   16, 1'b1, 1'b0, NO_OUTCOME},
    '{OP_SORTED,     8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_FULL, '0, '0, 5'd16}},
    '{OP_PUSH_FRONT, 8'd7,  64'd7,    1, 1'b0, 1'b1, '{ST_FULL, '0, '0, 5'd16}},
    '{OP_CLEAR,      8'h00, 64'h0,    1, 1'b0, 1'b1, '{ST_OK, '0, '0, 5'd0}}
  };

  sorted_key_list_table u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .key_in_i      (key_in_i),
    .payload_in_i  (payload_in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .key_out_o     (key_out_o),
    .payload_out_o (payload_out_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one command to the shadow list and returns the result it should give.
  function automatic outcome_t apply_command(input logic [OPC_W-1:0] op,
                                             input logic [KEY_W-1:0] key,
                                             input logic [PAY_W-1:0] payload);
    outcome_t res;
    int       ins_pos;
    int       take_pos;
    int       i;
    res      = NO_OUTCOME;
    ins_pos  = -1;
    take_pos = -1;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORTED: begin
        if (list_fill >= CAPACITY) res.status = ST_FULL;
        else if (op == OP_PUSH_FRONT) ins_pos = 0;
        else if (op == OP_PUSH_BACK) ins_pos = list_fill;
        else if (list_fill == 0 || key < list_keys[0]) ins_pos = 0;
        else begin
          // The front entry is skipped: a tie with it never lands in front.
          ins_pos = list_fill;
          for (i = list_fill - 1; i >= 1; i--)
            if (list_keys[i] >= key) ins_pos = i;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (list_fill == 0) res.status = ST_EMPTY;
        else take_pos = (op == OP_POP_FRONT) ? 0 : list_fill - 1;
      end
      OP_REMOVE: begin
        if (list_fill == 0) res.status = ST_EMPTY;
        else begin
          for (i = list_fill - 1; i >= 0; i--)
            if (list_keys[i] == key) take_pos = i;
          res.status = (take_pos >= 0) ? ST_OK : ST_NOT_FOUND;
        end
      end
      OP_CLEAR: list_fill = 0;
      default: ;
    endcase
    if (ins_pos >= 0) begin
      for (i = list_fill; i > ins_pos; i--) begin
        list_keys[i] = list_keys[i-1];
        list_pays[i] = list_pays[i-1];
      end
      list_keys[ins_pos] = key;
      list_pays[ins_pos] = payload;
      list_fill++;
    end
    if (take_pos >= 0) begin
      res.key     = list_keys[take_pos];
      res.payload = list_pays[take_pos];
      for (i = take_pos; i + 1 < list_fill; i++) begin
        list_keys[i] = list_keys[i+1];
        list_pays[i] = list_pays[i+1];
      end
      list_fill--;
    end
    res.count = list_fill[CNT_OUT_W-1:0];
    return res;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Mode 0 mostly inserts, mode 1 mostly removes, mode 2 mixes both evenly.
  function automatic logic [OPC_W-1:0] pick_command(input int mode);
    int r;
    int insert_share;
    r = $urandom_range(0, 99);
    if (r < 2) return OP_CLEAR;
    if (r < 4) return OPC_UNUSED;
    insert_share = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;
    if ($urandom_range(0, 99) < insert_share) begin
      case ($urandom_range(0, 3))
        0:       return OP_PUSH_FRONT;
        1:       return OP_PUSH_BACK;
        default: return OP_SORTED;
      endcase
    end
    case ($urandom_range(0, 2))
      0:       return OP_POP_FRONT;
      1:       return OP_POP_BACK;
      default: return OP_REMOVE;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    // A narrow range of keys gives plenty of ties for sorted insert and remove.
    if (r < 50) return KEY_W'($urandom_range(0, 7));
    if (r < 55) return 8'h00;
    if (r < 60) return 8'hFF;
    return KEY_W'($urandom_range(0, 255));
  endfunction

  task automatic offer_item(input int gap, input logic [OPC_W-1:0] op,
                            input logic [KEY_W-1:0] key, input logic [PAY_W-1:0] payload,
                            input bit typed, input outcome_t typed_outcome);
    outcome_t predicted;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    key_in_i     <= key;
    payload_in_i <= payload;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_command(op, key, payload);
    expected_results.push_back(typed ? typed_outcome : predicted);
  endtask

  // Result side: random stalls, plus a long hold whenever the sender asks for one.
  initial begin
    int r;
    int n;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req  = 1'b0;
        rx_holding   = 1'b1;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_holding   = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready_i <= 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 65) begin
          out_ready_i <= 1'b1;
          n = $urandom_range(20, 60);
        end else if (r < 95) begin
          out_ready_i <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    outcome_t want;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: status %0d key %0d payload %h count %0d",
                   status_o, key_out_o, payload_out_o, entry_count_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status || key_out_o !== want.key ||
            payload_out_o !== want.payload || entry_count_o !== want.count) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected status %0d key %0d payload %h count %0d, %s",
                     want.status, want.key, want.payload, want.count,
                     $sformatf("got status %0d key %0d payload %h count %0d",
                               status_o, key_out_o, payload_out_o, entry_count_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int               s;
    int               rep;
    int               item;
    int               mode;
    int               burst;
    logic [OPC_W-1:0] op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    mode  = 2;
    burst = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (s = 0; s < N_DIRECTED; s++) begin
      for (rep = 0; rep < directed_steps[s].reps; rep++) begin
        key     = directed_steps[s].key;
        payload = directed_steps[s].payload;
        if (directed_steps[s].rand_data) begin
          key     = KEY_W'($urandom_range(0, 255));
          payload = {$urandom, $urandom};
        end
        offer_item(idle_gap(), directed_steps[s].opcode, key, payload,
                   directed_steps[s].typed, directed_steps[s].outcome);
      end
    end

    for (item = 0; item < RANDOM_ITEMS; item++) begin
      if (item % 40 == 0) mode = $urandom_range(0, 2);
      if (item % 200 == 100) begin
        // Let the block drain completely before going on.
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (expected_results.size() != 0);
      end
      if (item == 300 || item == 700) begin
        // Back-to-back items against a stalled receiver fill the block up.
        rx_hold_req = 1'b1;
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while (!rx_holding);
        burst = 24;
      end else if (burst == 0 && $urandom_range(0, 49) == 0) begin
        burst = $urandom_range(10, 30);
      end
      op      = pick_command(mode);
      key     = pick_key();
      payload = {$urandom, $urandom};
      if (op == OP_REMOVE && list_fill > 0 && $urandom_range(0, 3) != 0)
        key = list_keys[$urandom_range(0, list_fill - 1)];
      offer_item((burst > 0) ? 0 : idle_gap(), op, key, payload, 1'b0, NO_OUTCOME);
      if (burst > 0) burst--;
    end

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/skl_pkg.sv
hw/rtl/skl_ram.sv
hw/rtl/sorted_key_list_table.sv
tb/sv/tb.sv
